>>> rtl/lpds_pkg.sv
package lpds_pkg;

   // Field and internal widths
   localparam int LIMB_W     = 64;
   localparam int DIGIT_W    = 5;                 // widest digit
   localparam int STREAM_W   = LIMB_W + DIGIT_W - 1; // limb plus up to four carry bits
   localparam int REM_W      = 7;                 // holds up to STREAM_W
   localparam int CLEN_W     = 3;
   localparam int CODE_W     = 8;
   localparam int COUNT_W    = 13;
   localparam int COUNT_MAX  = 8191;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIGIT_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ASCII_MODE = 2'd1;

   typedef struct packed {
      logic [LIMB_W-1:0] limb;
      logic              last_limb;
   } lpds_req_type;

   typedef struct packed {
      logic [CODE_W-1:0]  digit_code;
      logic               last_digit;
      logic [COUNT_W-1:0] digit_count;
   } lpds_rsp_type;

   // Digit presented by the shifter
   typedef struct packed {
      logic               busy;          // a digit is available
      logic [DIGIT_W-1:0] value;
      logic               end_of_number; // most significant digit of the number
   } lpds_digit_type;

   // Digit width as used: 0 acts as 1, 6 and 7 act as 5
   function automatic logic [CLEN_W-1:0] eff_bits_f(input logic [CSR_DATA_W-1:0] raw);
      logic [CLEN_W-1:0] b;
      b = raw;
      if (raw == 3'd0) begin
         b = 3'd1;
      end else if (raw > 3'd5) begin
         b = 3'd5;
      end
      return b;
   endfunction

   // Raw value or ASCII '0'-'9', 'a'-'v'
   function automatic logic [CODE_W-1:0] digit_code_f(input logic [DIGIT_W-1:0] v,
                                                      input logic ascii);
      logic [CODE_W-1:0] code;
      code = CODE_W'(v);
      if (ascii) begin
         if (v < 5'd10) begin
            code = 8'h30 + CODE_W'(v);
         end else begin
            code = 8'h57 + CODE_W'(v);
         end
      end
      return code;
   endfunction

endpackage

>>> rtl/lpds_digit_shifter.sv
module lpds_digit_shifter
   import lpds_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  lpds_req_type         req,
   input  logic [CLEN_W-1:0]    bits,
   input  logic                 step,
   input  logic                 clear_carry,
   output lpds_digit_type       dig
);

   logic [STREAM_W-1:0] sreg_ff, sreg_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic                last_ff, last_in;
   logic                busy_ff, busy_in;

   logic [STREAM_W-1:0] hi;
   logic [DIGIT_W-1:0]  mask;
   logic                hi_zero;
   logic                end_item;
   logic                carry_ok;
   logic [CLEN_W-1:0]   clen;
   logic [DIGIT_W-1:0]  carry;
   logic [STREAM_W-1:0] stream_load;

   // Stream with the current digit shifted out
   always_comb begin
      unique case (bits)
         3'd1:    hi = sreg_ff >> 1;
         3'd2:    hi = sreg_ff >> 2;
         3'd3:    hi = sreg_ff >> 3;
         3'd4:    hi = sreg_ff >> 4;
         default: hi = sreg_ff >> 5;
      endcase
   end

   assign mask    = DIGIT_W'((6'd1 << bits) - 6'd1);
   assign hi_zero = (hi == '0);

   // Last limb stops at the top set bit; others stop when less than a digit is left
   assign end_item = last_ff ? hi_zero : (rem_ff < REM_W'({bits, 1'b0}));

   assign dig.busy          = busy_ff;
   assign dig.value         = sreg_ff[DIGIT_W-1:0] & mask;
   assign dig.end_of_number = last_ff & hi_zero;

   // Leftover bits stay at the bottom of the stream; upper bits are zero
   assign carry_ok    = (rem_ff < REM_W'(bits));
   assign clen        = carry_ok ? rem_ff[CLEN_W-1:0] : '0;
   assign carry       = carry_ok ? sreg_ff[DIGIT_W-1:0] : '0;
   assign stream_load = (STREAM_W'(req.limb) << clen) | STREAM_W'(carry);

   always_comb begin
      sreg_in = sreg_ff;
      rem_in  = rem_ff;
      last_in = last_ff;
      busy_in = busy_ff;
      priority if (load) begin
         sreg_in = stream_load;
         rem_in  = REM_W'(LIMB_W) + REM_W'(clen);
         last_in = req.last_limb;
         busy_in = 1'b1;
      end else if (step) begin
         sreg_in = hi;
         rem_in  = rem_ff - REM_W'(bits);
         busy_in = ~end_item;
         if (last_ff && end_item) begin
            sreg_in = '0;
            rem_in  = '0;
            last_in = 1'b0;
         end
      end else if (clear_carry) begin
         sreg_in = '0;
         rem_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sreg_ff <= '0;
         rem_ff  <= '0;
         last_ff <= 1'b0;
         busy_ff <= 1'b0;
      end else begin
         sreg_ff <= sreg_in;
         rem_ff  <= rem_in;
         last_ff <= last_in;
         busy_ff <= busy_in;
      end
   end

   // A loaded limb always yields at least one digit
   assert property (@(posedge clock) disable iff (reset) load |=> busy_ff)
      else $error("shifter idle after load");

   // Inner limbs present a digit only when a full digit of bits is left
   assert property (@(posedge clock) disable iff (reset)
                    busy_ff && !last_ff |-> rem_ff >= REM_W'(bits))
      else $error("partial digit presented on inner limb");

endmodule

>>> rtl/lpds_out_stage.sv
module lpds_out_stage
   import lpds_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fill,
   input  lpds_rsp_type fill_data,
   output logic         can_fill,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output lpds_rsp_type rsp_data
);

   logic         valid_ff, valid_in;
   lpds_rsp_type data_ff, data_in;

   // Refill in the same cycle the held transfer completes
   assign can_fill = ~valid_ff | rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (fill) begin
         valid_in = 1'b1;
         data_in  = fill_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> rtl/limb_to_pow2_digit_serializer.sv
// Limb to power-of-two digit serializer. Takes 64-bit limbs least significant
// first and returns the number's digits in base 2^digit_bits (1 to 5 bits)
// least significant first, as raw values or ASCII ('0'-'9', 'a'-'v'). One digit
// leaves the shift register per clock while the output stage can take it. A
// limb yields (64 + carried bits) / digit_bits digits rounded down (64 for
// binary, 16 for hex), or digits up to its top set bit on the last limb, and the
// next limb is taken once its last digit has left. The final digit of a number carries the total digit
// count, saturated at MAX_LIMBS * 64 (at most 8191). A zero last limb gives a
// single digit, holding any carried bits. Writing digit_bits drops any bits carried between limbs.
module limb_to_pow2_digit_serializer
   import lpds_pkg::*;
#(
   parameter int MAX_LIMBS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lpds_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lpds_rsp_type          rsp_data,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CountCap = (MAX_LIMBS * LIMB_W < COUNT_MAX) ? MAX_LIMBS * LIMB_W
                                                               : COUNT_MAX;

   logic [CSR_DATA_W-1:0] digit_bits_ff;
   logic                  ascii_mode_ff;
   logic [COUNT_W-1:0]    cnt_ff, cnt_in;

   logic                  load;
   logic                  step;
   logic                  can_fill;
   logic                  clear_carry;
   logic [CLEN_W-1:0]     bits;
   logic [COUNT_W-1:0]    cnt_inc;
   lpds_digit_type        dig;
   lpds_rsp_type          fill_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         digit_bits_ff <= 3'd4;
         ascii_mode_ff <= 1'b1;
      end else if (csr_wen) begin
         if (csr_index == CSR_DIGIT_BITS) begin
            digit_bits_ff <= csr_wdata;
         end else if (csr_index == CSR_ASCII_MODE) begin
            ascii_mode_ff <= csr_wdata[0];
         end
      end
   end

   assign clear_carry = csr_wen && (csr_index == CSR_DIGIT_BITS);
   assign bits        = eff_bits_f(digit_bits_ff);

   // Handshake and digit stepping
   assign req_ready = ~dig.busy;
   assign load      = req_valid & req_ready;
   assign step      = dig.busy & can_fill;

   lpds_digit_shifter u_shifter (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .req         (req_data),
      .bits        (bits),
      .step        (step),
      .clear_carry (clear_carry),
      .dig         (dig)
   );

   // Saturating digit count for the current number
   assign cnt_inc = (cnt_ff < COUNT_W'(CountCap)) ? cnt_ff + 1'b1 : cnt_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (step) begin
         cnt_in = dig.end_of_number ? '0 : cnt_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign fill_data.digit_code  = digit_code_f(dig.value, ascii_mode_ff);
   assign fill_data.last_digit  = dig.end_of_number;
   assign fill_data.digit_count = dig.end_of_number ? cnt_inc : '0;

   lpds_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .fill      (step),
      .fill_data (fill_data),
      .can_fill  (can_fill),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Final digit always counts itself
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_data.last_digit |-> rsp_data.digit_count != '0)
      else $error("zero count on final digit");

   // Count restarts after the final digit of a number
   assert property (@(posedge clock) disable iff (reset)
                    step && dig.end_of_number |=> cnt_ff == '0)
      else $error("digit count not cleared after number");

endmodule

>>> tb/limb_to_pow2_digit_serializer_tb.sv
module limb_to_pow2_digit_serializer_tb;
   import lpds_pkg::*;

   localparam int MAX_LIMBS     = 64;
   localparam int COUNT_CEIL    = (MAX_LIMBS * 64 < COUNT_MAX) ? MAX_LIMBS * 64 : COUNT_MAX;
   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 40;
   localparam int QUIET_LIMIT   = 4000;
   localparam int PHASES        = 12;
   localparam int PHASE_LIMBS   = 31;
   localparam int LONG_LIMBS    = 70;
   localparam int PLAN_ROWS     = 33;

   typedef enum logic {ROW_LIMB, ROW_CSR} row_kind_type;

   // One line of the directed sequence: a limb transfer or a register write
   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] wdata;
      lpds_req_type          item;
      logic                  typed;   // single final digit given below, count 1
      logic [CODE_W-1:0]     code;
   } plan_row_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   lpds_req_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   lpds_rsp_type          rsp_data;
   logic                  csr_wen   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow of the block's registers and carry state
   logic [CSR_DATA_W-1:0] model_width_raw = 3'd4;
   logic                  model_ascii     = 1'b1;
   logic [DIGIT_W-1:0]    held_bits       = '0;
   int                    held_len        = 0;
   int                    number_digits   = 0;

   lpds_rsp_type pending_digits[$];
   lpds_rsp_type fresh_digits[$];
   plan_row_type plan [PLAN_ROWS];

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int errors         = 0;
   int quiet_cycles   = 0;
   int limbs_sent     = 0;
   int numbers_done   = 0;
   int digits_checked = 0;

   always #HALF_PERIOD clock = ~clock;

   limb_to_pow2_digit_serializer #(.MAX_LIMBS(MAX_LIMBS)) dut (.*);

   // Digit width in effect: 0 acts as 1, 6 and 7 act as 5
   function automatic int active_width();
      if (model_width_raw == 3'd0) return 1;
      if (model_width_raw > 3'd5) return 5;
      return int'(model_width_raw);
   endfunction

   task automatic emit_digit(input logic [DIGIT_W-1:0] value);
      lpds_rsp_type d;
      d = '0;
      if (!model_ascii) begin
         d.digit_code = CODE_W'(value);
      end else if (value < 5'd10) begin
         d.digit_code = 8'h30 + CODE_W'(value);
      end else begin
         d.digit_code = 8'h61 + CODE_W'(value - 5'd10);
      end
      fresh_digits.push_back(d);
      if (number_digits < COUNT_CEIL) number_digits++;
   endtask

   // Digits one limb gives, into fresh_digits; updates the carry and count
   task automatic predict_digits(input lpds_req_type item);
      logic [LIMB_W-1:0]  x;
      logic [DIGIT_W-1:0] mask;
      lpds_rsp_type       top;
      int                 b;
      int                 fix;
      int                 rest;
      int                 i;
      x = item.limb;
      b = active_width();
      mask = DIGIT_W'((1 << b) - 1);
      fresh_digits.delete();
      if (held_len >= b) begin
         held_len = 0;
         held_bits = '0;
      end
      rest = LIMB_W;
      if (item.last_limb) begin
         // stop at the top set bit; a zero limb still counts as one bit
         rest = 1;
         for (i = 0; i < LIMB_W; i++) begin
            if (x[i]) rest = i + 1;
         end
      end
      // digit that spans the limb boundary
      if (held_len != 0) begin
         fix = b - held_len;
         emit_digit((DIGIT_W'(x & ((64'd1 << fix) - 64'd1)) << held_len) | held_bits);
         x = x >> fix;
         rest = rest - fix;
      end
      if (item.last_limb) begin
         while (rest > 0) begin
            emit_digit(DIGIT_W'(x) & mask);
            x = x >> b;
            rest = rest - b;
         end
         top = fresh_digits.pop_back();
         top.last_digit = 1'b1;
         top.digit_count = COUNT_W'(number_digits);
         fresh_digits.push_back(top);
         held_len = 0;
         held_bits = '0;
         number_digits = 0;
         numbers_done++;
      end else begin
         while (rest >= b) begin
            emit_digit(DIGIT_W'(x) & mask);
            x = x >> b;
            rest = rest - b;
         end
         held_len = rest;
         held_bits = DIGIT_W'(x) & DIGIT_W'((1 << rest) - 1);
      end
   endtask

   // Register write, only once every expected digit is out and the block is quiet
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      req_valid <= 1'b0;
      while (pending_digits.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen <= 1'b0;
      if (idx == CSR_DIGIT_BITS) begin
         model_width_raw = val;
         held_len = 0;
         held_bits = '0;
      end else if (idx == CSR_ASCII_MODE) begin
         model_ascii = val[0];
      end
   endtask

   // Offer one limb; entered and left at a falling edge
   task automatic send_limb(input lpds_req_type item, input logic typed,
                            input lpds_rsp_type typed_digit);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      predict_digits(item);
      if (typed) begin
         pending_digits.push_back(typed_digit);
      end else begin
         foreach (fresh_digits[i]) pending_digits.push_back(fresh_digits[i]);
      end
      limbs_sent++;
      @(negedge clock);
   endtask

   function automatic lpds_req_type random_limb(input logic last);
      lpds_req_type item;
      item.last_limb = last;
      case ($urandom_range(0, 9))
         0: item.limb = '0;
         1: item.limb = '1;
         2, 3, 4: item.limb = {$urandom, $urandom} >> $urandom_range(0, LIMB_W - 1);
         default: item.limb = {$urandom, $urandom};
      endcase
      return item;
   endfunction

   function automatic plan_row_type limb_row(input logic [LIMB_W-1:0] limb, input logic last);
      plan_row_type r;
      r = '{ROW_LIMB, '0, '0, '0, 1'b0, '0};
      r.item.limb = limb;
      r.item.last_limb = last;
      return r;
   endfunction

   function automatic plan_row_type typed_row(input logic [LIMB_W-1:0] limb,
                                              input logic [CODE_W-1:0] code);
      plan_row_type r;
      r = limb_row(limb, 1'b1);
      r.typed = 1'b1;
      r.code = code;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] val);
      plan_row_type r;
      r = '{ROW_CSR, idx, val, '0, 1'b0, '0};
      return r;
   endfunction

   // Receiver: random backpressure at the falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Digit checker and stall watchdog
   always @(posedge clock) begin
      lpds_rsp_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d digits outstanding",
                     $time, QUIET_LIMIT, pending_digits.size());
            $display("limb_to_pow2_digit_serializer test failed");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_digits.size() == 0) begin
               errors++;
               $display("%0t: unexpected digit code %h last %b count %0d", $time,
                        rsp_data.digit_code, rsp_data.last_digit, rsp_data.digit_count);
            end else begin
               want = pending_digits.pop_front();
               digits_checked++;
               if (rsp_data.digit_code !== want.digit_code ||
                   rsp_data.last_digit !== want.last_digit ||
                   rsp_data.digit_count !== want.digit_count) begin
                  errors++;
                  $display("%0t: expected code %h last %b count %0d, got code %h last %b count %0d",
                           $time, want.digit_code, want.last_digit, want.digit_count,
                           rsp_data.digit_code, rsp_data.last_digit, rsp_data.digit_count);
               end
            end
         end
      end
   end

   initial begin
      lpds_rsp_type typed_digit;

      // Directed sequence; reset state is hex digits as ASCII
      plan = '{
         typed_row(64'h0, 8'h30),                          // zero last limb gives '0'
         typed_row(64'hf, 8'h66),
         limb_row('1, 1'b1),
         limb_row(64'h0123_4567_89ab_cdef, 1'b0),
         limb_row(64'h1, 1'b1),
         csr_row(CSR_DIGIT_BITS, 3'd1),                    // binary, 64 digits a limb
         limb_row('1, 1'b0),
         limb_row(64'h0, 1'b1),
         limb_row(64'h8000_0000_0000_0000, 1'b1),
         csr_row(CSR_DIGIT_BITS, 3'd5),                    // 4 bits carried per limb
         limb_row('1, 1'b0),
         limb_row(64'h0, 1'b1),                            // zero last limb under a carry
         limb_row('1, 1'b0),
         limb_row(64'h1, 1'b1),                            // short last limb under a carry
         csr_row(CSR_ASCII_MODE, 3'd0),
         typed_row(64'h1f, 8'h1f),
         csr_row(CSR_DIGIT_BITS, 3'd3),
         limb_row('1, 1'b0),
         limb_row('1, 1'b1),
         csr_row(CSR_DIGIT_BITS, 3'd0),                    // acts as binary
         typed_row(64'h1, 8'h01),
         csr_row(CSR_DIGIT_BITS, 3'd7),                    // acts as 5 bits
         limb_row('1, 1'b0),
         limb_row(64'h0, 1'b1),
         csr_row(CSR_DIGIT_BITS, 3'd3),
         limb_row('1, 1'b0),
         csr_row(CSR_DIGIT_BITS, 3'd2),                    // drops carry mid-number
         limb_row(64'h5, 1'b1),
         csr_row(CSR_DIGIT_BITS, 3'd6),
         csr_row(CSR_ASCII_MODE, 3'd1),
         typed_row(64'h1f, 8'h76),
         csr_row(CSR_DIGIT_BITS, 3'd2),
         limb_row(64'h5555_5555_5555_5555, 1'b1)
      };

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[r]) begin
         if (plan[r].kind == ROW_CSR) begin
            write_reg(plan[r].idx, plan[r].wdata);
         end else begin
            typed_digit = '0;
            typed_digit.digit_code = plan[r].code;
            typed_digit.last_digit = 1'b1;
            typed_digit.digit_count = COUNT_W'(1);
            send_limb(plan[r].item, plan[r].typed, typed_digit);
         end
      end

      // Random numbers, phases rotate through the idle and stall patterns
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 59;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 59;
            end
            default: begin
               send_idle_pct = 10;
               rsp_stall_pct = 10;
            end
         endcase
         // numbers may be left open here, so width writes also land mid-number
         write_reg(CSR_DIGIT_BITS, CSR_DATA_W'((phase * 3) % 8));
         write_reg(CSR_ASCII_MODE, CSR_DATA_W'($urandom_range(0, 1)));
         if (phase == 3) begin
            // binary number long enough to saturate the digit count
            for (int n = 0; n < LONG_LIMBS; n++) send_limb(random_limb(1'b0), 1'b0, '0);
            send_limb(random_limb(1'b1), 1'b0, '0);
         end
         for (int n = 0; n < PHASE_LIMBS; n++) begin
            send_limb(random_limb($urandom_range(0, 3) == 0), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d limbs closing %0d numbers; %0d digits checked", limbs_sent,
               numbers_done, digits_checked);
      $display("Covered digit widths 0-7 as written, raw and ASCII output, count saturation");
      if (errors == 0) begin
         $display("limb_to_pow2_digit_serializer test passed");
      end else begin
         $display("limb_to_pow2_digit_serializer test failed");
      end
      $finish;
   end

endmodule
